// File: src/slsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsc_pkg
// Shared types and codes for the sorted list set compare block.
// ----------------------------------------------------------------------------
package slsc_pkg;

   localparam int SLSC_LIST_DEPTH = 32;
   localparam int SLSC_KEY_BITS   = 64;
   localparam int KEY_W           = 64;

   localparam logic [1:0] ACT_LOAD_A = 2'd0;
   localparam logic [1:0] ACT_LOAD_B = 2'd1;
   localparam logic [1:0] ACT_RUN    = 2'd2;

   localparam logic [1:0] CLASS_COMMON = 2'd0;
   localparam logic [1:0] CLASS_ONLY_A = 2'd1;
   localparam logic [1:0] CLASS_ONLY_B = 2'd2;

   typedef struct packed {
      logic [1:0]       action;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]       list_class;
      logic [KEY_W-1:0] key_out;
      logic             last_of_run;
   } rsp_type;

endpackage

// File: src/slsc_list_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsc_list_mem
// Key store for one list: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module slsc_list_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 64,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sorted_list_set_compare_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_set_compare_top
// Loads two ascending key lists and merges them into common / only-A /
// only-B results.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a rising edge with start high and busy low.
//   Load A / load B beats append req_data.key to a list; busy stays low,
//   so loads can follow back to back. Loads into a full list are dropped.
//   A run beat raises busy (unless both lists are empty) and walks both
//   lists with shared < and > comparators. For each result a FETCH state
//   reads both heads from the list stores and a COMPARE state compares
//   them and steps the pointers. A run over lists of sizes na and nb
//   gives n results (max(na,nb) <= n <= na+nb); the first result appears
//   after the FETCH and COMPARE states and the output register. A run over
//   two empty lists gives nothing.
//   Each result is on rsp_data for one cycle with rsp_strobe high; the
//   last one of a run has last_of_run set. The receiver cannot stall.
//   The run clears both list counts. Reset clears the counts, the
//   sequencer and the strobe; list contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_set_compare_top
   import slsc_pkg::*;
#(
   parameter int LIST_DEPTH = SLSC_LIST_DEPTH,
   parameter int KEY_BITS   = SLSC_KEY_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_FETCH   = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] ptr_a_ff, ptr_a_in;
   logic [CNT_W-1:0] ptr_b_ff, ptr_b_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                wr_a, wr_b;
   logic [KEY_BITS-1:0] wr_key;
   logic [KEY_BITS-1:0] head_a, head_b;
   logic                have_a, have_b;
   logic                a_less, a_more;
   logic                take_a, take_b;
   logic                done;

   assign accept = start && (state_ff == ST_IDLE);
   assign wr_key = req_data.key[KEY_BITS-1:0];
   assign wr_a   = accept && (req_data.action == ACT_LOAD_A)
                   && (count_a_ff != CNT_W'(LIST_DEPTH));
   assign wr_b   = accept && (req_data.action == ACT_LOAD_B)
                   && (count_b_ff != CNT_W'(LIST_DEPTH));

   slsc_list_mem #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (KEY_BITS)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[IDX_W-1:0]),
      .wr_data (wr_key),
      .rd_addr (ptr_a_ff[IDX_W-1:0]),
      .rd_data (head_a)
   );

   slsc_list_mem #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (KEY_BITS)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[IDX_W-1:0]),
      .wr_data (wr_key),
      .rd_addr (ptr_b_ff[IDX_W-1:0]),
      .rd_data (head_b)
   );

   assign have_a = ptr_a_ff < count_a_ff;
   assign have_b = ptr_b_ff < count_b_ff;
   assign a_less = head_a < head_b;
   assign a_more = head_a > head_b;

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      rsp_data_in = rsp_data_ff;
      if (have_a && have_b) begin
         if (a_less) begin
            take_a = 1'b1;
            rsp_data_in.list_class = CLASS_ONLY_A;
            rsp_data_in.key_out    = KEY_W'(head_a);
         end else if (a_more) begin
            take_b = 1'b1;
            rsp_data_in.list_class = CLASS_ONLY_B;
            rsp_data_in.key_out    = KEY_W'(head_b);
         end else begin
            take_a = 1'b1;
            take_b = 1'b1;
            rsp_data_in.list_class = CLASS_COMMON;
            rsp_data_in.key_out    = KEY_W'(head_a);
         end
      end else if (have_a) begin
         take_a = 1'b1;
         rsp_data_in.list_class = CLASS_ONLY_A;
         rsp_data_in.key_out    = KEY_W'(head_a);
      end else begin
         take_b = 1'b1;
         rsp_data_in.list_class = CLASS_ONLY_B;
         rsp_data_in.key_out    = KEY_W'(head_b);
      end
      ptr_a_in = take_a ? ptr_a_ff + CNT_W'(1) : ptr_a_ff;
      ptr_b_in = take_b ? ptr_b_ff + CNT_W'(1) : ptr_b_ff;
      done = (ptr_a_in >= count_a_ff) && (ptr_b_in >= count_b_ff);
      rsp_data_in.last_of_run = done;
   end

   always_comb begin
      state_in      = state_ff;
      count_a_in    = wr_a ? count_a_ff + CNT_W'(1) : count_a_ff;
      count_b_in    = wr_b ? count_b_ff + CNT_W'(1) : count_b_ff;
      rsp_strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.action == ACT_RUN)) begin
               if ((count_a_ff != '0) || (count_b_ff != '0)) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            rsp_strobe_in = 1'b1;
            if (done) begin
               state_in   = ST_IDLE;
               count_a_in = '0;
               count_b_in = '0;
            end else begin
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         ptr_a_ff      <= '0;
         ptr_b_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (state_ff == ST_IDLE) begin
            ptr_a_ff <= '0;
            ptr_b_ff <= '0;
         end else if (state_ff == ST_COMPARE) begin
            ptr_a_ff <= ptr_a_in;
            ptr_b_ff <= ptr_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_COMPARE) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: verif/sorted_list_set_compare_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_set_compare_top_tb
// Drives load A / load B / run beats into the list compare block and checks
// every merge result against an in-bench merge of the same two lists. It
// starts with hand-picked lists, then streams random list pairs, some
// overfilled and some unsorted, with stray unused actions and empty runs.
// Sender gaps are random, with bursts of back-to-back beats.
// ----------------------------------------------------------------------------
module sorted_list_set_compare_top_tb
   import slsc_pkg::*;
();

   localparam int DEPTH       = SLSC_LIST_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TARGET_BEATS = 330;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   class merge_scoreboard;
      logic [KEY_W-1:0] keys_a[DEPTH];
      logic [KEY_W-1:0] keys_b[DEPTH];
      int unsigned      fill_a;
      int unsigned      fill_b;
      rsp_type          pending[$];
      int unsigned      errors;
      int unsigned      matched;

      function new();
         fill_a  = 0;
         fill_b  = 0;
         errors  = 0;
         matched = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void push_key(logic [1:0] cls, logic [KEY_W-1:0] key);
         rsp_type r;
         r.list_class  = cls;
         r.key_out     = key;
         r.last_of_run = 1'b0;
         pending = {pending, r};
      endfunction

      function void note_beat(req_type beat);
         int unsigned ia;
         int unsigned ib;
         int          first;
         rsp_type     tail;
         ia = 0;
         ib = 0;
         case (beat.action)
            ACT_LOAD_A: begin
               if (fill_a < DEPTH) begin
                  keys_a[fill_a] = beat.key;
                  fill_a++;
               end
            end
            ACT_LOAD_B: begin
               if (fill_b < DEPTH) begin
                  keys_b[fill_b] = beat.key;
                  fill_b++;
               end
            end
            ACT_RUN: begin
               first = pending.size();
               while (ia < fill_a || ib < fill_b) begin
                  if (ib >= fill_b || (ia < fill_a && keys_a[ia] < keys_b[ib])) begin
                     push_key(CLASS_ONLY_A, keys_a[ia]);
                     ia++;
                  end else if (ia >= fill_a || keys_a[ia] > keys_b[ib]) begin
                     push_key(CLASS_ONLY_B, keys_b[ib]);
                     ib++;
                  end else begin
                     push_key(CLASS_COMMON, keys_a[ia]);
                     ia++;
                     ib++;
                  end
               end
               if (pending.size() > first) begin
                  tail = pending[pending.size()-1];
                  tail.last_of_run = 1'b1;
                  pending[pending.size()-1] = tail;
               end
               fill_a = 0;
               fill_b = 0;
            end
            default: ;
         endcase
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result class %0d key %h last %b",
                             got.list_class, got.key_out, got.last_of_run));
            return;
         end
         want = pending.pop_front();
         if (got.list_class !== want.list_class)
            report($sformatf("class %0d, want %0d (key %h)",
                             got.list_class, want.list_class, want.key_out));
         if (got.key_out !== want.key_out)
            report($sformatf("key %h, want %h", got.key_out, want.key_out));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, want %b (key %h)",
                             got.last_of_run, want.last_of_run, want.key_out));
         matched++;
      endtask
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   merge_scoreboard board;
   int unsigned     cycle_count = 0;
   int unsigned     burst_left  = 0;
   int unsigned     loads_sent  = 0;
   int unsigned     runs_sent   = 0;
   int unsigned     noise_sent  = 0;

   sorted_list_set_compare_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending.size());
         $display("sorted_list_set_compare_top_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result(rsp_data);
   end

   task automatic send_beat(logic [1:0] act, logic [KEY_W-1:0] key);
      int unsigned gap;
      req_type     beat;
      beat.action = act;
      beat.key    = key;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 7);
         if ($urandom_range(0, 39) == 0)
            burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      board.note_beat(beat);
      case (act)
         ACT_LOAD_A, ACT_LOAD_B: loads_sent++;
         ACT_RUN:                runs_sent++;
         default:                noise_sent++;
      endcase
   endtask

   task automatic send_list_pair();
      logic [KEY_W-1:0] list_a[$];
      logic [KEY_W-1:0] list_b[$];
      logic [KEY_W-1:0] cursor;
      int unsigned      total;
      int unsigned      key_mode;
      int unsigned      role;
      int unsigned      all_common;
      list_a.delete();
      list_b.delete();
      cursor     = {$urandom, $urandom};
      key_mode   = $urandom_range(0, 9);
      all_common = 0;
      if ($urandom_range(0, 11) == 0) begin
         total      = $urandom_range(28, 40);
         all_common = $urandom_range(0, 1);
      end else begin
         total = $urandom_range(0, 10);
      end
      repeat (total) begin
         if (key_mode < 4)
            cursor = cursor + $urandom_range(1, 3);
         else if (key_mode < 8)
            cursor = cursor + {$urandom_range(0, 3), $urandom};
         else
            cursor = {$urandom, $urandom};
         role = all_common ? 0 : $urandom_range(0, 2);
         if (role != 2) list_a = {list_a, cursor};
         if (role != 1) list_b = {list_b, cursor};
      end
      while (list_a.size() > 0 || list_b.size() > 0) begin
         if ($urandom_range(0, 24) == 0)
            send_beat(ACT_UNUSED, {$urandom, $urandom});
         if (list_b.size() == 0 || (list_a.size() > 0 && $urandom_range(0, 1)))
            send_beat(ACT_LOAD_A, list_a.pop_front());
         else
            send_beat(ACT_LOAD_B, list_b.pop_front());
      end
      send_beat(ACT_RUN, {$urandom, $urandom});
      if ($urandom_range(0, 9) == 0)
         send_beat(ACT_RUN, {$urandom, $urandom});
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(ACT_RUN, 64'h0);
      send_beat(ACT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);

      send_beat(ACT_LOAD_A, 64'h0);
      send_beat(ACT_LOAD_A, 64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(ACT_LOAD_B, 64'h0);
      send_beat(ACT_LOAD_B, 64'h8000_0000_0000_0000);
      send_beat(ACT_LOAD_B, 64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(ACT_RUN, 64'hFFFF_FFFF_FFFF_FFFF);

      send_beat(ACT_LOAD_A, 64'd5);
      send_beat(ACT_RUN, 64'h0);

      send_beat(ACT_LOAD_B, 64'd7);
      send_beat(ACT_LOAD_B, 64'd3);
      send_beat(ACT_RUN, 64'h0);

      send_beat(ACT_LOAD_A, 64'd4);
      send_beat(ACT_LOAD_A, 64'd4);
      send_beat(ACT_LOAD_B, 64'd4);
      send_beat(ACT_RUN, 64'h0);

      send_beat(ACT_LOAD_A, 64'd1);
      send_beat(ACT_LOAD_B, 64'd2);
      send_beat(ACT_LOAD_A, 64'd9);
      send_beat(ACT_RUN, 64'h0);

      while (loads_sent + runs_sent < TARGET_BEATS)
         send_list_pair();
      start <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d loads, %0d runs and %0d unused-action beats",
               loads_sent, runs_sent, noise_sent);
      $display("checked %0d merge results, %0d mismatches", board.matched, board.errors);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("sorted_list_set_compare_top_tb OK");
      end else begin
         $display("sorted_list_set_compare_top_tb NOT OK");
      end
      $finish;
   end

endmodule
